/* rtl/cra_pkg.sv */
// Shared types and constants of the capped running average block.
// Used by cra_div, cra_datapath, cra_ctrl and capped_running_average.
package cra_pkg;

    localparam int          SAMPLE_W   = 32;
    localparam int          VALUE_W    = 16;
    localparam int          DIVISOR_W  = VALUE_W + 1;
    localparam int          NUM_W      = 2 * VALUE_W;
    localparam int          DIV_STEPS  = VALUE_W;
    localparam int          STEP_CNT_W = $clog2(DIV_STEPS);
    localparam logic [15:0] CAP_RESET  = 16'd1000;
    localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic mul;        // form numerator and divisor
        logic div_start;  // launch the divider
        logic commit;     // update state, load output register
    } cra_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bypass;     // zero sample or empty state: no division
        logic div_busy;
        logic out_free;   // output register can take a result
    } cra_sts_t;

endpackage

/* rtl/capped_running_average.sv */
// Top level of the capped running average: stream in, stream out, one cap register.
// Depends on cra_pkg, cra_ctrl and cra_datapath.
//
// Each input transaction carries one duration sample and yields exactly one output
// transaction with the running average, the sample count and an accepted flag. Zero
// samples leave the state alone; samples above 65535 are clamped. A sample that goes
// through the division passes capture, multiply, divider launch, the one-bit-per-cycle
// restoring divider, completion and commit before the next one is accepted; a zero
// sample, or the first one after the state is empty, skips multiply and division.
// The output register lets a new sample be accepted while the previous result still
// waits for m_axis_tready. weight_cap resets to 1000; the user must write it through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module capped_running_average (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // weight_cap
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] average_value, [31:16] sample_count
    output logic        m_axis_tuser    // [0] accepted
);

    cra_pkg::cra_cmd_t cmd;
    cra_pkg::cra_sts_t sts;

    cra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cra_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .sample_seconds (s_axis_tdata),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_axis_tready),
        .m_tvalid       (m_axis_tvalid),
        .average_value  (m_axis_tdata[15:0]),
        .sample_count   (m_axis_tdata[31:16]),
        .accepted       (m_axis_tuser)
    );

    // an accepted sample always leaves a nonzero average and count
    a_acc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] != 16'd0
                                          && m_axis_tdata[31:16] != 16'd0)
        else $error("accepted result with zero average or count");

    // no new transaction is taken while the divider runs
    a_ready_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !sts.div_busy)
        else $error("input ready while divider busy");

    // one sample in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // a result is only committed into a free output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result overwrote a pending output");

    // output valid only drops after the result was taken
    a_valid_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("output result dropped without handshake");

endmodule

/* rtl/cra_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cra_pkg for widths; quotient is known to fit in VALUE_W bits.
module cra_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [cra_pkg::NUM_W-1:0]        dividend,
    input  logic [cra_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             busy,
    output logic [cra_pkg::VALUE_W-1:0]      quotient
);

    logic [cra_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [cra_pkg::VALUE_W-1:0]    quo_reg, quo_next;
    logic [cra_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic [cra_pkg::DIVISOR_W:0]    trial;

    // dividend < 2^16 * divisor, so the high half is already below the divisor
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[cra_pkg::VALUE_W-1]};
        if (start) begin
            rem_next  = {1'b0, dividend[cra_pkg::NUM_W-1:cra_pkg::VALUE_W]};
            quo_next  = dividend[cra_pkg::VALUE_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = cra_pkg::DIVISOR_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[cra_pkg::VALUE_W-2:0], 1'b1};
            end else begin
                rem_next = trial[cra_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[cra_pkg::VALUE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cra_pkg::STEP_CNT_W'(cra_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/cra_datapath.sv */
// Datapath: weight cap register, average and count state, multiplier,
// divider and output register. Depends on cra_pkg and cra_div.
module cra_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data,
    input  logic [cra_pkg::SAMPLE_W-1:0]     sample_seconds,
    input  cra_pkg::cra_cmd_t                cmd,
    output cra_pkg::cra_sts_t                sts,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [cra_pkg::VALUE_W-1:0]      average_value,
    output logic [cra_pkg::VALUE_W-1:0]      sample_count,
    output logic                             accepted
);

    logic [15:0]                      cap_reg;
    logic [cra_pkg::VALUE_W-1:0]      avg_reg, avg_next;
    logic [cra_pkg::VALUE_W-1:0]      count_reg, count_next;
    logic [cra_pkg::VALUE_W-1:0]      sample_reg;
    logic                             zero_reg;
    logic [cra_pkg::NUM_W-1:0]        num_reg;
    logic [cra_pkg::DIVISOR_W-1:0]    divisor_reg;
    logic [cra_pkg::VALUE_W-1:0]      weight;
    logic [cra_pkg::NUM_W-1:0]        product;
    logic                             first;
    logic                             below_cap;
    logic                             div_busy;
    logic [cra_pkg::VALUE_W-1:0]      quotient;
    logic                             out_valid_reg;
    logic [cra_pkg::VALUE_W-1:0]      out_avg_reg;
    logic [cra_pkg::VALUE_W-1:0]      out_count_reg;
    logic                             out_acc_reg;

    assign below_cap = count_reg < cap_reg;
    assign weight    = below_cap ? count_reg : cap_reg;
    assign first     = (count_reg == '0) || (avg_reg == '0);
    assign product   = {{cra_pkg::VALUE_W{1'b0}}, avg_reg}
                     * {{cra_pkg::VALUE_W{1'b0}}, weight};

    cra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        avg_next   = avg_reg;
        count_next = count_reg;
        if (!zero_reg) begin
            if (first) begin
                avg_next   = sample_reg;
                count_next = cra_pkg::VALUE_W'(1);
            end else begin
                avg_next = quotient;
                if (below_cap) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= cra_pkg::CAP_RESET;
            avg_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                avg_reg       <= avg_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            sample_reg <= (|sample_seconds[cra_pkg::SAMPLE_W-1:cra_pkg::VALUE_W])
                        ? cra_pkg::SAMPLE_MAX : sample_seconds[cra_pkg::VALUE_W-1:0];
            zero_reg   <= (sample_seconds == '0);
        end
        if (cmd.mul) begin
            num_reg     <= product + {{cra_pkg::VALUE_W{1'b0}}, sample_reg};
            divisor_reg <= {1'b0, weight} + cra_pkg::DIVISOR_W'(1);
        end
        if (cmd.commit) begin
            out_avg_reg   <= avg_next;
            out_count_reg <= count_next;
            out_acc_reg   <= !zero_reg;
        end
    end

    assign sts.bypass   = zero_reg || first;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign average_value = out_avg_reg;
    assign sample_count  = out_count_reg;
    assign accepted      = out_acc_reg;

endmodule

/* rtl/cra_ctrl.sv */
// Sequencer of the capped running average: one sample at a time.
// Depends on cra_pkg for the command and status structs.
module cra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cra_pkg::cra_sts_t sts,
    output cra_pkg::cra_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (sts.bypass) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for capped_running_average: duration samples go in on the
// slave stream, and each result is checked against a running-average predictor.
// Depends on cra_pkg and the capped_running_average RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 5000;   // cycles with no transaction before giving up
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [15:0] average;
        logic [15:0] count;
        logic        accepted;
    } avg_result_t;

    // Predicts the running average and compares each output transaction in order.
    class avg_scoreboard;
        logic [15:0]  weight_cap;
        logic [15:0]  run_avg;
        logic [15:0]  run_count;
        avg_result_t  expected_q[$];
        int unsigned  failures;
        int unsigned  checked;
        int unsigned  samples;
        int unsigned  zero_samples;
        int unsigned  clamped;
        int unsigned  cap_writes;

        function new();
            weight_cap   = cra_pkg::CAP_RESET;
            run_avg      = '0;
            run_count    = '0;
            failures     = 0;
            checked      = 0;
            samples      = 0;
            zero_samples = 0;
            clamped      = 0;
            cap_writes   = 0;
        endfunction

        function void set_cap(logic [15:0] value);
            weight_cap = value;
            cap_writes++;
        endfunction

        function void note_sample(logic [31:0] raw);
            avg_result_t res;
            logic [15:0] clipped;
            logic [16:0] weight;
            logic [33:0] numer;
            samples++;
            res.accepted = (raw != '0);
            if (raw == '0) begin
                zero_samples++;
            end else begin
                if (raw > 32'(cra_pkg::SAMPLE_MAX)) begin
                    clipped = cra_pkg::SAMPLE_MAX;
                    clamped++;
                end else begin
                    clipped = raw[15:0];
                end
                if (run_count == '0 || run_avg == '0) begin
                    run_avg   = clipped;
                    run_count = 16'd1;
                end else begin
                    weight  = (run_count < weight_cap) ? {1'b0, run_count} : {1'b0, weight_cap};
                    numer   = 34'(run_avg) * 34'(weight) + 34'(clipped);
                    run_avg = 16'(numer / (34'(weight) + 34'd1));
                    if (run_count < weight_cap)
                        run_count = run_count + 16'd1;
                end
            end
            res.average = run_avg;
            res.count   = run_count;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [15:0] got_avg, logic [15:0] got_count,
                                   logic got_acc);
            avg_result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: avg %0d count %0d accepted %0b",
                             got_avg, got_count, got_acc);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.average !== got_avg || want.count !== got_count
                    || want.accepted !== got_acc) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch #%0d: exp avg %0d cnt %0d acc %0b, got %0d %0d %0b",
                             checked, want.average, want.count, want.accepted,
                             got_avg, got_count, got_acc);
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] sample_seconds
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] average_value, [31:16] sample_count
    logic        m_axis_tuser;         // [0] accepted

    avg_scoreboard sb;
    int unsigned   quiet_cycles = 0;
    int unsigned   burst_left   = 0;
    int unsigned   ready_mode   = 0;
    int unsigned   mode_timer   = 0;
    int unsigned   rx_cycle     = 0;

    capped_running_average DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Monitor: config writes, results and inputs, all sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.set_cap(cfg_wr_data);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver backpressure: the pattern switches whenever a random countdown runs out.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (mode_timer == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_timer <= $urandom_range(100, 400);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        case (ready_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_axis_tready <= rx_cycle[3];
            end
        endcase
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // One input transaction; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [31:0] value);
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sender in bursts, with random gaps between them.
    task automatic send_paced(input logic [31:0] value);
        int unsigned gap;
        int unsigned r;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, 6) : $urandom_range(7, 30);
            burst_left = $urandom_range(1, $urandom_range(1, 40));
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        send_sample(value);
    endtask

    // Hold off the sender until every result is back.
    task automatic drain();
        if (sb.expected_q.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (sb.expected_q.size() != 0) @(negedge aclk);
        end
    endtask

    task automatic write_cap(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] draw_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 30)
            return $urandom_range(1, 300);
        else if (r < 60)
            return $urandom_range(1, 65535);
        else if (r < 75)
            return 32'(sb.run_avg) + $urandom_range(0, 20);   // near the current average
        else if (r < 92)
            return $urandom;
        else begin
            case ($urandom_range(0, 3))
                0: return 32'd1;
                1: return 32'd65535;
                2: return 32'd65536;
                default: return 32'hFFFF_FFFF;
            endcase
        end
    endfunction

    task automatic run_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == n / 2)
                drain();
            send_paced(draw_sample());
        end
    endtask

    initial begin : main
        logic [31:0] opening[12];
        logic [31:0] cap_zero_set[5];
        logic [31:0] cap_one_set[4];
        logic [15:0] late_caps[6];
        sb = new();
        // zero on empty state, first sample, clamping and bit patterns
        opening = '{32'd0, 32'd1, 32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd65536,
                    32'd2, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'd0, 32'd300};
        cap_zero_set = '{32'd500, 32'd0, 32'd70000, 32'd1, 32'd12345};
        cap_one_set  = '{32'd100, 32'd1, 32'hFFFF_FFFF, 32'd0};
        late_caps = '{16'd2, 16'($urandom_range(3, 40)), 16'd65534,
                      16'($urandom_range(1, 65535)), cra_pkg::CAP_RESET,
                      16'($urandom_range(1, 8))};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening[i]) send_paced(opening[i]);
        write_cap(16'd0);          // weight zero: average follows the sample
        foreach (cap_zero_set[i]) send_paced(cap_zero_set[i]);
        write_cap(16'd1);
        foreach (cap_one_set[i]) send_paced(cap_one_set[i]);

        write_cap(16'hFFFF);
        run_random(410);
        write_cap(16'd40);         // cap now below the count
        run_random(150);
        foreach (late_caps[i]) begin
            write_cap(late_caps[i]);
            run_random(120);
        end

        drain();
        repeat (30) @(negedge aclk);

        if (sb.expected_q.size() != 0) begin
            sb.failures += sb.expected_q.size();
            $display("%0d results never arrived", sb.expected_q.size());
        end
        $display("covered %0d samples (%0d zero, %0d clamped), %0d results checked",
                 sb.samples, sb.zero_samples, sb.clamped, sb.checked);
        $display("cap written %0d times, incl. 0, 1, 65535, below count; %0d failures",
                 sb.cap_writes, sb.failures);
        if (sb.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/cra_pkg.sv
rtl/cra_div.sv
rtl/cra_datapath.sv
rtl/cra_ctrl.sv
rtl/capped_running_average.sv
tb/tb_top.sv
